// File: src/dsma_pkg.sv
`timescale 1ns / 1ps

package dsma_pkg;

  localparam int MAX_SHORT_LEN = 64;
  localparam int MAX_LONG_LEN  = 256;

  localparam int PRICE_W     = 32;
  localparam int SHORT_LEN_W = 7;
  localparam int LONG_LEN_W  = 9;
  localparam int SHORT_POS_W = $clog2(MAX_SHORT_LEN);
  localparam int LONG_POS_W  = $clog2(MAX_LONG_LEN);
  localparam int SHORT_SUM_W = 38;
  localparam int LONG_SUM_W  = 40;

  // Shared divider: dividend as wide as the long sum, divisor as wide as the long length
  localparam int DIVIDEND_W  = LONG_SUM_W;
  localparam int DIVISOR_W   = LONG_LEN_W;
  localparam int QUO_W       = PRICE_W;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_STEPS   = QUO_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = LONG_LEN_W;

  localparam logic [CFG_INDEX_W-1:0] REG_SHORT_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_LENGTH  = 2'd1;

  localparam logic [SHORT_LEN_W-1:0] SHORT_LENGTH_RESET = 7'd16;
  localparam logic [LONG_LEN_W-1:0]  LONG_LENGTH_RESET  = 9'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_SHORT_START,
    ST_SHORT_WAIT,
    ST_LONG_START,
    ST_LONG_WAIT,
    ST_OUTPUT
  } state_t;

  // Length of zero acts as one, length above the buffer depth saturates
  function automatic logic [SHORT_LEN_W-1:0] clamp_short(input logic [SHORT_LEN_W-1:0] len);
    logic [SHORT_LEN_W-1:0] r;
    if (len == '0) begin
      r = SHORT_LEN_W'(1);
    end else if (len > SHORT_LEN_W'(MAX_SHORT_LEN)) begin
      r = SHORT_LEN_W'(MAX_SHORT_LEN);
    end else begin
      r = len;
    end
    return r;
  endfunction

  function automatic logic [LONG_LEN_W-1:0] clamp_long(input logic [LONG_LEN_W-1:0] len);
    logic [LONG_LEN_W-1:0] r;
    if (len == '0) begin
      r = LONG_LEN_W'(1);
    end else if (len > LONG_LEN_W'(MAX_LONG_LEN)) begin
      r = LONG_LEN_W'(MAX_LONG_LEN);
    end else begin
      r = len;
    end
    return r;
  endfunction

endpackage

// File: src/dual_simple_moving_average.sv
`timescale 1ns / 1ps
// Dual-window moving average: short and long window means of a price stream.
// Items are taken one at a time: a new item waits until the last result has
// entered the output register. One radix-4 divider computes both means.
// Reset (rst, synchronous): clears sums, positions and window fill flags, so both
// windows read as all zero; lengths return to 16 (short) and 64 (long).

module dual_simple_moving_average
  import dsma_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // item input
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [PRICE_W-1:0]     price,
  // result output
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [QUO_W-1:0]       short_average,
  output logic [QUO_W-1:0]       long_average,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  state_t state;
  state_t state_next;

  // Configuration registers
  logic [SHORT_LEN_W-1:0] short_length;
  logic [LONG_LEN_W-1:0]  long_length;
  logic [SHORT_LEN_W-1:0] short_eff;
  logic [LONG_LEN_W-1:0]  long_eff;

  // Window bookkeeping. A window fills in order 0, 1, 2, ... after a clear,
  // so an entry not yet written is exactly one at or past the write position
  // before the first wrap: a single full flag marks all entries valid.
  logic [SHORT_SUM_W-1:0] short_sum;
  logic [LONG_SUM_W-1:0]  long_sum;
  logic [SHORT_POS_W-1:0] short_position;
  logic [LONG_POS_W-1:0]  long_position;
  logic                   short_full;
  logic                   long_full;

  logic [PRICE_W-1:0]     price_q;
  logic [PRICE_W-1:0]     short_rdata;
  logic [PRICE_W-1:0]     long_rdata;
  logic [PRICE_W-1:0]     short_old;
  logic [PRICE_W-1:0]     long_old;
  logic [SHORT_LEN_W-1:0] short_pos_inc;
  logic [LONG_LEN_W-1:0]  long_pos_inc;
  logic                   short_wrap;
  logic                   long_wrap;

  logic                   in_accept;
  logic                   cfg_write;
  logic                   out_free;
  logic                   mem_we;
  logic                   div_start;
  logic                   div_long;
  logic                   div_done;
  logic [DIVIDEND_W-1:0]  div_dividend;
  logic [DIVISOR_W-1:0]   div_divisor;
  logic [QUO_W-1:0]       div_quotient;
  logic [QUO_W-1:0]       short_quot;

  assign short_eff = clamp_short(short_length);
  assign long_eff  = clamp_long(long_length);

  assign in_accept = in_valid && !in_stall;
  assign cfg_write = cfg_valid && cfg_ready;
  // Output register can take a new result at this edge
  assign out_free  = !out_valid || !out_stall;

  // Overwritten sample: zero until the window has wrapped once
  assign short_old = short_full ? short_rdata : '0;
  assign long_old  = long_full  ? long_rdata  : '0;

  assign short_pos_inc = SHORT_LEN_W'(short_position) + SHORT_LEN_W'(1);
  assign long_pos_inc  = LONG_LEN_W'(long_position) + LONG_LEN_W'(1);
  assign short_wrap    = (short_pos_inc == short_eff);
  assign long_wrap     = (long_pos_inc == long_eff);

  // Ring buffers: the registered read port follows the write position, so the
  // oldest entry is on the read data by the time ST_UPDATE overwrites it
  dsma_ram #(
    .DEPTH (MAX_SHORT_LEN),
    .WIDTH (PRICE_W)
  ) u_short_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (short_position),
    .wdata (price_q),
    .raddr (short_position),
    .rdata (short_rdata)
  );

  dsma_ram #(
    .DEPTH (MAX_LONG_LEN),
    .WIDTH (PRICE_W)
  ) u_long_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (long_position),
    .wdata (price_q),
    .raddr (long_position),
    .rdata (long_rdata)
  );

  // One divider serves both means: short first, then long
  assign div_dividend = div_long ? long_sum : DIVIDEND_W'(short_sum);
  assign div_divisor  = div_long ? long_eff : DIVISOR_W'(short_eff);

  dsma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_READ;
        end
      end
      ST_READ:        state_next = ST_UPDATE;
      ST_UPDATE:      state_next = ST_SHORT_START;
      ST_SHORT_START: state_next = ST_SHORT_WAIT;
      ST_SHORT_WAIT: begin
        if (div_done) begin
          state_next = ST_LONG_START;
        end
      end
      ST_LONG_START:  state_next = ST_LONG_WAIT;
      ST_LONG_WAIT: begin
        if (div_done) begin
          state_next = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:        state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    div_long  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
      end
      ST_UPDATE: begin
        mem_we = 1'b1;
      end
      ST_SHORT_START: begin
        div_start = 1'b1;
      end
      ST_LONG_START: begin
        div_start = 1'b1;
        div_long  = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the sample for the update and the buffer write
  always_ff @(posedge clk) begin
    if (in_accept) begin
      price_q <= price;
    end
  end

  // Lengths, sums, positions and fill flags. A length write clears its window.
  always_ff @(posedge clk) begin
    if (rst) begin
      short_length   <= SHORT_LENGTH_RESET;
      long_length    <= LONG_LENGTH_RESET;
      short_sum      <= '0;
      long_sum       <= '0;
      short_position <= '0;
      long_position  <= '0;
      short_full     <= 1'b0;
      long_full      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SHORT_LENGTH: begin
          short_length   <= cfg_data[SHORT_LEN_W-1:0];
          short_sum      <= '0;
          short_position <= '0;
          short_full     <= 1'b0;
        end
        REG_LONG_LENGTH: begin
          long_length   <= cfg_data;
          long_sum      <= '0;
          long_position <= '0;
          long_full     <= 1'b0;
        end
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end else if (mem_we) begin
      // Drop the oldest sample, add the new one, advance with wrap
      short_sum <= short_sum - SHORT_SUM_W'(short_old) + SHORT_SUM_W'(price_q);
      long_sum  <= long_sum - LONG_SUM_W'(long_old) + LONG_SUM_W'(price_q);
      short_position <= short_wrap ? '0 : short_pos_inc[SHORT_POS_W-1:0];
      long_position  <= long_wrap ? '0 : long_pos_inc[LONG_POS_W-1:0];
      short_full <= short_full | short_wrap;
      long_full  <= long_full | long_wrap;
    end
  end

  // Keep the short mean while the divider works on the long one
  always_ff @(posedge clk) begin
    if (state == ST_SHORT_WAIT && div_done) begin
      short_quot <= div_quotient;
    end
  end

  // Output register: parts the sequencer from a stalled consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUTPUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUTPUT && out_free) begin
      short_average <= short_quot;
      long_average  <= div_quotient;
    end
  end

endmodule

// File: src/dsma_ram.sv
`timescale 1ns / 1ps

module dsma_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/dsma_div.sv
`timescale 1ns / 1ps

module dsma_div
  import dsma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [QUO_W-1:0]      quotient
);

  // Restoring division, two quotient bits a cycle. The high dividend bits
  // start as the partial remainder; callers guarantee they are below the divisor.
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] rem_next;
  logic [QUO_W-1:0]     quo_next;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;

  always_comb begin
    logic [DIVISOR_W:0]   t;
    logic [DIVISOR_W-1:0] r;
    logic [QUO_W-1:0]     q;
    r = rem;
    q = quotient;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      t = {r, q[QUO_W-1]};
      q = {q[QUO_W-2:0], 1'b0};
      if (t >= (DIVISOR_W+1)'(dvs)) begin
        t    = t - (DIVISOR_W+1)'(dvs);
        q[0] = 1'b1;
      end
      r = t[DIVISOR_W-1:0];
    end
    rem_next = r;
    quo_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= DIVISOR_W'(dividend[DIVIDEND_W-1:QUO_W]);
      quotient <= dividend[QUO_W-1:0];
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= quo_next;
    end
  end

endmodule
